@@ design/pet_pkg.sv @@
// shared types, codes and limits of the prescaled elapsed timer bank
package pet_pkg;

	localparam int PRESCALE_W = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int WIDE_W     = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECONDS_PER_MINUTE = 1'b1;

	localparam logic [PRESCALE_W-1:0] TICKS_PER_SECOND_RST   = 6'd61;
	localparam logic [PRESCALE_W-1:0] SECONDS_PER_MINUTE_RST = 6'd60;

	// item modes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2
	} mode_t;

	// timer selection codes
	localparam logic [2:0] TMR_PUMP_RUN        = 3'd0;
	localparam logic [2:0] TMR_PUMP_STOP       = 3'd1;
	localparam logic [2:0] TMR_COMP_RUN        = 3'd2;
	localparam logic [2:0] TMR_COMP_STOP       = 3'd3;
	localparam logic [2:0] TMR_DEFROST_STOP    = 3'd4;
	localparam logic [2:0] TMR_DEFROST_ELAPSED = 3'd5;
	localparam logic [2:0] TMR_DEFROST_SCAN    = 3'd6;

	// saturation limits
	localparam logic [WIDE_W-1:0] LIM_PUMP_RUN        = 13'd30;
	localparam logic [WIDE_W-1:0] LIM_PUMP_STOP       = 13'd360;
	localparam logic [WIDE_W-1:0] LIM_COMP_RUN        = 13'd120;
	localparam logic [WIDE_W-1:0] LIM_COMP_STOP       = 13'd180;
	localparam logic [WIDE_W-1:0] LIM_DEFROST_STOP    = 13'd30;
	localparam logic [WIDE_W-1:0] LIM_DEFROST_ELAPSED = 13'd4800;
	localparam logic [WIDE_W-1:0] LIM_DEFROST_SCAN    = 13'd40;

	// advance a running timer by one, holding at its limit
	function automatic logic [WIDE_W-1:0] advance(input logic [WIDE_W-1:0] v,
			input logic [WIDE_W-1:0] lim);
		logic [WIDE_W-1:0] r;
		r = v;
		if ((v != '0) && (v < lim)) begin
			r = v + 13'd1;
		end
		return r;
	endfunction

endpackage

@@ design/prescaled_elapsed_timer_bank.sv @@
// top level of the prescaled elapsed timer bank
//
// usage
// - input channel (in_valid / in_stall, fields mode and timer_index) carries
//   tick, start and stop items; one result item leaves per input item
// - output channel (out_valid / out_stall) carries the second and minute
//   pulses and all seven timer values after the item's update
// - cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the tick
//   and second prescaler reload values; always ready, write only when idle
// - path: an accepted item passes the input register, then the update
//   logic, then the result register
// - throughput: one item per cycle while out_stall does not hold the result
//   register; the timer state is read and written in the cycle the item leaves
//   the input register, so items follow each other with no gap
// - stall: when out_stall holds a full result register, a full input
//   register holds too and in_stall rises; nothing is dropped or repeated
// - reset: prescalers load 61 and 60, the reload registers take the same
//   values, all timers clear to zero, both registers empty
//
module prescaled_elapsed_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  timer_index,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pet_pkg::PRESCALE_W-1:0] cfg_data,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic        second_pulse,
	output logic        minute_pulse,
	output logic [4:0]  pump_run_value,
	output logic [8:0]  pump_stop_value,
	output logic [6:0]  comp_run_value,
	output logic [7:0]  comp_stop_value,
	output logic [4:0]  defrost_stop_value,
	output logic [12:0] defrost_elapsed_value,
	output logic [5:0]  defrost_scan_value
);

	// reload registers
	logic [pet_pkg::PRESCALE_W-1:0] ticks_per_second_q;
	logic [pet_pkg::PRESCALE_W-1:0] seconds_per_minute_q;

	// prescalers and timers
	logic [pet_pkg::PRESCALE_W-1:0] tick_cnt_q;
	logic [pet_pkg::PRESCALE_W-1:0] sec_cnt_q;
	logic [4:0]  pump_run_q;
	logic [8:0]  pump_stop_q;
	logic [6:0]  comp_run_q;
	logic [7:0]  comp_stop_q;
	logic [4:0]  defrost_stop_q;
	logic [12:0] defrost_elapsed_q;
	logic [5:0]  defrost_scan_q;

	// input register
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [2:0]  idx_s1;

	// next values
	logic [pet_pkg::PRESCALE_W-1:0] tick_cnt_d;
	logic [pet_pkg::PRESCALE_W-1:0] sec_cnt_d;
	logic [pet_pkg::PRESCALE_W-1:0] tick_dec;
	logic [pet_pkg::PRESCALE_W-1:0] sec_dec;
	logic        sec_d;
	logic        min_d;
	logic [4:0]  pump_run_d;
	logic [8:0]  pump_stop_d;
	logic [6:0]  comp_run_d;
	logic [7:0]  comp_stop_d;
	logic [4:0]  defrost_stop_d;
	logic [12:0] defrost_elapsed_d;
	logic [5:0]  defrost_scan_d;
	logic [12:0] set_val;
	logic        set_en;

	// handshake
	logic out_free;
	logic adv_s1;

	assign out_free  = !out_valid || !out_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	assign tick_dec = tick_cnt_q - 6'd1;
	assign sec_dec  = sec_cnt_q - 6'd1;

	// state update for the item in the input register
	always_comb begin
		tick_cnt_d        = tick_cnt_q;
		sec_cnt_d         = sec_cnt_q;
		sec_d             = 1'b0;
		min_d             = 1'b0;
		pump_run_d        = pump_run_q;
		pump_stop_d       = pump_stop_q;
		comp_run_d        = comp_run_q;
		comp_stop_d       = comp_stop_q;
		defrost_stop_d    = defrost_stop_q;
		defrost_elapsed_d = defrost_elapsed_q;
		defrost_scan_d    = defrost_scan_q;
		set_en            = 1'b0;
		set_val           = '0;
		unique case (mode_s1)
			pet_pkg::MODE_TICK: begin
				tick_cnt_d = tick_dec;
				if (tick_dec == '0) begin
					// a second completes: reload, step second timers
					tick_cnt_d = ticks_per_second_q;
					sec_d      = 1'b1;
					sec_cnt_d  = sec_dec;
					pump_run_d = 5'(pet_pkg::advance(13'(pump_run_q),
						pet_pkg::LIM_PUMP_RUN));
					pump_stop_d = 9'(pet_pkg::advance(13'(pump_stop_q),
						pet_pkg::LIM_PUMP_STOP));
					comp_run_d = 7'(pet_pkg::advance(13'(comp_run_q),
						pet_pkg::LIM_COMP_RUN));
					comp_stop_d = 8'(pet_pkg::advance(13'(comp_stop_q),
						pet_pkg::LIM_COMP_STOP));
					defrost_stop_d = 5'(pet_pkg::advance(13'(defrost_stop_q),
						pet_pkg::LIM_DEFROST_STOP));
					defrost_elapsed_d = pet_pkg::advance(defrost_elapsed_q,
						pet_pkg::LIM_DEFROST_ELAPSED);
					if (sec_dec == '0) begin
						// a minute completes too
						sec_cnt_d      = seconds_per_minute_q;
						min_d          = 1'b1;
						defrost_scan_d = 6'(pet_pkg::advance(13'(defrost_scan_q),
							pet_pkg::LIM_DEFROST_SCAN));
					end
				end
			end
			pet_pkg::MODE_START: begin
				set_en  = 1'b1;
				set_val = 13'd1;
			end
			pet_pkg::MODE_STOP: begin
				set_en  = 1'b1;
				set_val = 13'd0;
			end
			default: begin
				// unused mode leaves everything as is
			end
		endcase
		if (set_en) begin
			unique case (idx_s1)
				pet_pkg::TMR_PUMP_RUN:        pump_run_d        = 5'(set_val);
				pet_pkg::TMR_PUMP_STOP:       pump_stop_d       = 9'(set_val);
				pet_pkg::TMR_COMP_RUN:        comp_run_d        = 7'(set_val);
				pet_pkg::TMR_COMP_STOP:       comp_stop_d       = 8'(set_val);
				pet_pkg::TMR_DEFROST_STOP:    defrost_stop_d    = 5'(set_val);
				pet_pkg::TMR_DEFROST_ELAPSED: defrost_elapsed_d = set_val;
				pet_pkg::TMR_DEFROST_SCAN:    defrost_scan_d    = 6'(set_val);
				default: begin
					// no timer behind this index
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			idx_s1  <= timer_index;
		end
	end

	// reload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q   <= pet_pkg::TICKS_PER_SECOND_RST;
			seconds_per_minute_q <= pet_pkg::SECONDS_PER_MINUTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pet_pkg::REG_TICKS_PER_SECOND:   ticks_per_second_q   <= cfg_data;
				pet_pkg::REG_SECONDS_PER_MINUTE: seconds_per_minute_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// prescalers and timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q        <= pet_pkg::TICKS_PER_SECOND_RST;
			sec_cnt_q         <= pet_pkg::SECONDS_PER_MINUTE_RST;
			pump_run_q        <= '0;
			pump_stop_q       <= '0;
			comp_run_q        <= '0;
			comp_stop_q       <= '0;
			defrost_stop_q    <= '0;
			defrost_elapsed_q <= '0;
			defrost_scan_q    <= '0;
		end else if (adv_s1) begin
			tick_cnt_q        <= tick_cnt_d;
			sec_cnt_q         <= sec_cnt_d;
			pump_run_q        <= pump_run_d;
			pump_stop_q       <= pump_stop_d;
			comp_run_q        <= comp_run_d;
			comp_stop_q       <= comp_stop_d;
			defrost_stop_q    <= defrost_stop_d;
			defrost_elapsed_q <= defrost_elapsed_d;
			defrost_scan_q    <= defrost_scan_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			second_pulse          <= sec_d;
			minute_pulse          <= min_d;
			pump_run_value        <= pump_run_d;
			pump_stop_value       <= pump_stop_d;
			comp_run_value        <= comp_run_d;
			comp_stop_value       <= comp_stop_d;
			defrost_stop_value    <= defrost_stop_d;
			defrost_elapsed_value <= defrost_elapsed_d;
			defrost_scan_value    <= defrost_scan_d;
		end
	end

endmodule

@@ test/prescaled_elapsed_timer_bank_tb.sv @@
// self-checking testbench of the prescaled elapsed timer bank
`timescale 1ns / 100ps

module prescaled_elapsed_timer_bank_tb;

	// run length guard, far above the slowest legal run
	localparam int CYCLE_LIMIT  = 300000;
	// settle time after the last expected result is back
	localparam int SETTLE_CYCLES = 8;
	// saturation run: one tick per second, enough to pin every timer but
	// defrost elapsed
	localparam int SATURATE_TICKS = 380;

	// codes the package leaves out
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] TMR_NONE    = 3'd7;

	// one result item, fields in port order
	typedef struct packed {
		logic        second_pulse;
		logic        minute_pulse;
		logic [4:0]  pump_run;
		logic [8:0]  pump_stop;
		logic [6:0]  comp_run;
		logic [7:0]  comp_stop;
		logic [4:0]  defrost_stop;
		logic [12:0] defrost_elapsed;
		logic [5:0]  defrost_scan;
	} timer_report_t;

	// one row of the directed table; typed rows carry a hand-written result
	typedef struct packed {
		logic [1:0]    m;
		logic [2:0]    idx;
		logic          typed;
		timer_report_t want;
	} stim_row_t;

	// clock, reset and ports
	logic clk;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = pet_pkg::MODE_TICK;
	logic [2:0]  timer_index = pet_pkg::TMR_PUMP_RUN;

	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pet_pkg::CFG_IDX_W-1:0]  cfg_index = pet_pkg::REG_TICKS_PER_SECOND;
	logic [pet_pkg::PRESCALE_W-1:0] cfg_data = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        second_pulse;
	logic        minute_pulse;
	logic [4:0]  pump_run_value;
	logic [8:0]  pump_stop_value;
	logic [6:0]  comp_run_value;
	logic [7:0]  comp_stop_value;
	logic [4:0]  defrost_stop_value;
	logic [12:0] defrost_elapsed_value;
	logic [5:0]  defrost_scan_value;

	// hand-written expectation travels next to the payload
	logic          cur_typed = 1'b0;
	timer_report_t cur_want = '0;

	// idle rates in percent for sender and receiver
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// predictor state: prescalers, reload registers, timers
	logic [pet_pkg::PRESCALE_W-1:0] tick_left  = pet_pkg::TICKS_PER_SECOND_RST;
	logic [pet_pkg::PRESCALE_W-1:0] sec_left   = pet_pkg::SECONDS_PER_MINUTE_RST;
	logic [pet_pkg::PRESCALE_W-1:0] tps_reload = pet_pkg::TICKS_PER_SECOND_RST;
	logic [pet_pkg::PRESCALE_W-1:0] spm_reload = pet_pkg::SECONDS_PER_MINUTE_RST;
	logic [pet_pkg::WIDE_W-1:0]     timer_val [7];

	timer_report_t pending_reports [$];
	timer_report_t predicted;
	timer_report_t got;
	timer_report_t want;
	stim_row_t     directed_rows [$];

	int mismatch_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int seconds_seen = 0;
	int minutes_seen = 0;
	int cycle_count = 0;

	prescaled_elapsed_timer_bank dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.mode                  (mode),
		.timer_index           (timer_index),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.second_pulse          (second_pulse),
		.minute_pulse          (minute_pulse),
		.pump_run_value        (pump_run_value),
		.pump_stop_value       (pump_stop_value),
		.comp_run_value        (comp_run_value),
		.comp_stop_value       (comp_stop_value),
		.defrost_stop_value    (defrost_stop_value),
		.defrost_elapsed_value (defrost_elapsed_value),
		.defrost_scan_value    (defrost_scan_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturation point of each timer
	function automatic logic [pet_pkg::WIDE_W-1:0] limit_of(input logic [2:0] idx);
		case (idx)
			pet_pkg::TMR_PUMP_RUN:        limit_of = pet_pkg::LIM_PUMP_RUN;
			pet_pkg::TMR_PUMP_STOP:       limit_of = pet_pkg::LIM_PUMP_STOP;
			pet_pkg::TMR_COMP_RUN:        limit_of = pet_pkg::LIM_COMP_RUN;
			pet_pkg::TMR_COMP_STOP:       limit_of = pet_pkg::LIM_COMP_STOP;
			pet_pkg::TMR_DEFROST_STOP:    limit_of = pet_pkg::LIM_DEFROST_STOP;
			pet_pkg::TMR_DEFROST_ELAPSED: limit_of = pet_pkg::LIM_DEFROST_ELAPSED;
			default:                      limit_of = pet_pkg::LIM_DEFROST_SCAN;
		endcase
	endfunction

	// advance the bank by one item and report every timer after the update
	function automatic timer_report_t step_bank(input logic [1:0] m, input logic [2:0] idx);
		timer_report_t r;
		int k;
		r = '0;
		case (m)
			pet_pkg::MODE_TICK: begin
				// 6-bit wrap: a zero reload gives a period of 64
				tick_left = tick_left - 6'd1;
				if (tick_left == '0) begin
					tick_left = tps_reload;
					r.second_pulse = 1'b1;
					sec_left = sec_left - 6'd1;
					// running second-timers count up and hold at their limit
					for (k = 0; k < 6; k++) begin
						if (timer_val[k] != '0 && timer_val[k] < limit_of(k[2:0]))
							timer_val[k] = timer_val[k] + 13'd1;
					end
					if (sec_left == '0) begin
						sec_left = spm_reload;
						r.minute_pulse = 1'b1;
						if (timer_val[pet_pkg::TMR_DEFROST_SCAN] != '0 &&
								timer_val[pet_pkg::TMR_DEFROST_SCAN] <
								pet_pkg::LIM_DEFROST_SCAN)
							timer_val[pet_pkg::TMR_DEFROST_SCAN] =
								timer_val[pet_pkg::TMR_DEFROST_SCAN] + 13'd1;
					end
				end
			end
			pet_pkg::MODE_START: begin
				if (idx != TMR_NONE)
					timer_val[idx] = 13'd1;
			end
			pet_pkg::MODE_STOP: begin
				if (idx != TMR_NONE)
					timer_val[idx] = '0;
			end
			default: ;
		endcase
		r.pump_run        = timer_val[pet_pkg::TMR_PUMP_RUN][4:0];
		r.pump_stop       = timer_val[pet_pkg::TMR_PUMP_STOP][8:0];
		r.comp_run        = timer_val[pet_pkg::TMR_COMP_RUN][6:0];
		r.comp_stop       = timer_val[pet_pkg::TMR_COMP_STOP][7:0];
		r.defrost_stop    = timer_val[pet_pkg::TMR_DEFROST_STOP][4:0];
		r.defrost_elapsed = timer_val[pet_pkg::TMR_DEFROST_ELAPSED];
		r.defrost_scan    = timer_val[pet_pkg::TMR_DEFROST_SCAN][5:0];
		return r;
	endfunction

	function automatic stim_row_t row(input logic [1:0] m, input logic [2:0] idx,
			input logic typed, input timer_report_t w);
		row.m     = m;
		row.idx   = idx;
		row.typed = typed;
		row.want  = w;
	endfunction

	task automatic check_field(input string name, input logic [12:0] exp_v,
			input logic [12:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// track all three handshakes at each edge; all sampled values are pre-edge
	always @(posedge clk) begin
		if (arst_n) begin
			// reload writes only touch the reload registers, never the running count
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pet_pkg::REG_TICKS_PER_SECOND:   tps_reload = cfg_data;
					pet_pkg::REG_SECONDS_PER_MINUTE: spm_reload = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predicted = step_bank(mode, timer_index);
				pending_reports.push_back(cur_typed ? cur_want : predicted);
				items_accepted++;
			end
			if (out_valid && !out_stall) begin
				got = {second_pulse, minute_pulse, pump_run_value, pump_stop_value,
					comp_run_value, comp_stop_value, defrost_stop_value,
					defrost_elapsed_value, defrost_scan_value};
				if (pending_reports.size() == 0) begin
					$display("%0t: result item with none expected, got %h", $time, got);
					mismatch_count++;
				end else begin
					want = pending_reports.pop_front();
					check_field("second_pulse", 13'(want.second_pulse),
						13'(got.second_pulse));
					check_field("minute_pulse", 13'(want.minute_pulse),
						13'(got.minute_pulse));
					check_field("pump_run_value", 13'(want.pump_run), 13'(got.pump_run));
					check_field("pump_stop_value", 13'(want.pump_stop),
						13'(got.pump_stop));
					check_field("comp_run_value", 13'(want.comp_run), 13'(got.comp_run));
					check_field("comp_stop_value", 13'(want.comp_stop),
						13'(got.comp_stop));
					check_field("defrost_stop_value", 13'(want.defrost_stop),
						13'(got.defrost_stop));
					check_field("defrost_elapsed_value", want.defrost_elapsed,
						got.defrost_elapsed);
					check_field("defrost_scan_value", 13'(want.defrost_scan),
						13'(got.defrost_scan));
				end
				results_checked++;
				seconds_seen += int'(got.second_pulse);
				minutes_seen += int'(got.minute_pulse);
			end
		end
	end

	// receiver back-pressure, one draw per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d results still expected",
				$time, pending_reports.size());
			$display("Verification failed");
			$finish;
		end
	end

	// offer one item; random gaps carry junk payload with valid low
	task automatic push_item(input logic [1:0] m, input logic [2:0] idx,
			input logic typed, input timer_report_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid    <= 1'b0;
			mode        <= 2'($urandom_range(3));
			timer_index <= 3'($urandom_range(7));
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		timer_index <= idx;
		cur_typed   <= typed;
		cur_want    <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// mostly ticks so timers climb, with starts, stops and unused codes mixed in
	task automatic push_random_item();
		int pick;
		logic [1:0] m;
		pick = $urandom_range(99);
		if (pick < 70)
			m = pet_pkg::MODE_TICK;
		else if (pick < 84)
			m = pet_pkg::MODE_START;
		else if (pick < 94)
			m = pet_pkg::MODE_STOP;
		else
			m = MODE_UNUSED;
		push_item(m, 3'($urandom_range(7)), 1'b0, '0);
	endtask

	// wait until every expected result is back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both reload registers back to back, valid held across the pair
	task automatic program_reloads(input logic [5:0] tps, input logic [5:0] spm);
		cfg_valid <= 1'b1;
		cfg_index <= pet_pkg::REG_TICKS_PER_SECOND;
		cfg_data  <= tps;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= pet_pkg::REG_SECONDS_PER_MINUTE;
		cfg_data  <= spm;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		timer_report_t pump_run_one;
		logic [5:0] ph_tps [7];
		logic [5:0] ph_spm [7];
		int ph_items [7];
		int p;
		int n;

		for (n = 0; n < 7; n++)
			timer_val[n] = '0;
		pump_run_one = '0;
		pump_run_one.pump_run = 5'd1;

		// reload settings per random phase: minimum, maximum, zero (period 64),
		// a random small pair and a few short periods so pulses come often
		ph_tps = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd1, 6'd3, 6'd1};
		ph_spm = '{6'd1, 6'd63, 6'd2, 6'd0, 6'd1, 6'd4, 6'd2};
		ph_items = '{150, 100, 150, 200, 150, 150, 150};
		ph_tps[4] = 6'($urandom_range(1, 5));
		ph_spm[4] = 6'($urandom_range(1, 5));

		// directed table at reset settings; typed rows are plain from reset state
		directed_rows.push_back(row(pet_pkg::MODE_TICK, pet_pkg::TMR_PUMP_RUN, 1'b1, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_PUMP_RUN, 1'b1,
			pump_run_one));
		directed_rows.push_back(row(pet_pkg::MODE_STOP, pet_pkg::TMR_PUMP_RUN, 1'b1, '0));
		// unused mode and unused timer index change nothing
		directed_rows.push_back(row(MODE_UNUSED, TMR_NONE, 1'b1, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, TMR_NONE, 1'b1, '0));
		directed_rows.push_back(row(pet_pkg::MODE_STOP, TMR_NONE, 1'b1, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_PUMP_RUN, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_PUMP_STOP, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_COMP_RUN, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_COMP_STOP, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_DEFROST_STOP, 1'b0,
			'0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_DEFROST_ELAPSED,
			1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_DEFROST_SCAN, 1'b0,
			'0));
		directed_rows.push_back(row(MODE_UNUSED, pet_pkg::TMR_DEFROST_SCAN, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_TICK, TMR_NONE, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_STOP, pet_pkg::TMR_DEFROST_STOP, 1'b0,
			'0));
		directed_rows.push_back(row(pet_pkg::MODE_STOP, pet_pkg::TMR_DEFROST_SCAN, 1'b0,
			'0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_DEFROST_STOP, 1'b0,
			'0));
		directed_rows.push_back(row(pet_pkg::MODE_START, pet_pkg::TMR_COMP_RUN, 1'b0, '0));
		directed_rows.push_back(row(pet_pkg::MODE_TICK, pet_pkg::TMR_DEFROST_ELAPSED, 1'b0,
			'0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles sometimes, receiver mostly stalls
		send_idle_pct = 38;
		recv_idle_pct = 87;
		foreach (directed_rows[i])
			push_item(directed_rows[i].m, directed_rows[i].idx, directed_rows[i].typed,
				directed_rows[i].want);
		drain();

		for (p = 0; p < 7; p++) begin
			// swap roles for the middle phases, then run without idling
			if (p == 2) begin
				send_idle_pct = 87;
				recv_idle_pct = 38;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// prescalers keep counting across the write; only the next reload changes
			program_reloads(ph_tps[p], ph_spm[p]);
			for (n = 0; n < ph_items[p]; n++)
				push_random_item();
			drain();
		end

		// one second per tick: start every timer and tick until most hold at limit
		program_reloads(6'd1, 6'd1);
		for (n = 0; n < 7; n++)
			push_item(pet_pkg::MODE_START, n[2:0], 1'b0, '0);
		for (n = 0; n < SATURATE_TICKS; n++)
			push_item(pet_pkg::MODE_TICK, 3'($urandom_range(7)), 1'b0, '0);
		drain();

		$display("%0d items driven over 9 reload settings including 0, 1 and 63,",
			items_accepted);
		$display("%0d results checked with %0d second and %0d minute pulses",
			results_checked, seconds_seen, minutes_seen);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
